// File: src/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, cond)
`define ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: src/rrts_pkg.sv
// Package for the round-robin task scheduler: sizes, codes and state types.
// Depends on nothing.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int TID_W     = 4;
  localparam int CNT_W     = 5;

  // Task states.
  typedef enum logic [2:0] {
    ST_INVALID  = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_BLOCKED  = 3'd4
  } task_st_e;

  // Event codes.
  typedef enum logic [2:0] {
    FN_MKRDY = 3'd0,
    FN_BLOCK = 3'd1,
    FN_UNBLK = 3'd2,
    FN_SLEEP = 3'd3,
    FN_YIELD = 3'd4,
    FN_TICK  = 3'd5,
    FN_WAKE  = 3'd6,
    FN_BAD   = 3'd7
  } func_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_IDLE   = 2'd1,
    CFG_SLICE  = 2'd2,
    CFG_TICKMS = 2'd3
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_FD_RD, S_FD_CMP, S_SH_RD, S_SH_WR, S_CONT, S_DIV, S_SLP,
    S_TK_CHK, S_TK_RDW, S_TK_CMP, S_TK_SLICE, S_RS0, S_RS1, S_RS2, S_RS3
  } seq_e;

endpackage

// File: src/round_robin_task_scheduler_core.sv
// Round-robin task scheduler core: sequencer, queue/stack memory, wake-time memory.
// Depends on rrts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// An item is taken when start is high and busy is low. Its result appears for
// one cycle with done_o, and the receiver cannot hold it off. Every operation is
// done by a sequencer around one 32-entry memory holding the ready queue and the
// sleep stack (one read and one write a cycle) and a 16-entry wake-time memory.
// Make-ready, unblock, unknown and rejected events finish without raising busy.
// Block of a ready task and wake search the queue or the stack up to and
// including the match, shift each later entry down one place and then finish.
// Sleep runs the bit-serial divider and then pushes the task onto the sleep
// stack. A reschedule (yield, block or sleep of the current task, slice expiry)
// takes the head of the queue when the queue holds a task and the idle task
// otherwise, and does nothing more while scheduling is disabled. A tick checks
// each sleeper, removes each one that wakes and shifts the entries above it
// down, then checks the slice. done_o rises in the same cycle as busy falls,
// and a new item may be taken in that cycle.
module round_robin_task_scheduler_core import rrts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [3:0]  task_id_i,
  input  logic [31:0] sleep_ms_i,
  output logic        done_o,
  output logic [3:0]  running_task_o,
  output logic        switched_o,
  output logic        status_o,
  output logic [63:0] tick_count_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic        en_q;
  logic [3:0]  idle_q;
  logic [15:0] slice_cfg_q;
  logic [9:0]  tickms_q;

  // Control state.
  seq_e                   state_q, state_d;
  logic                   done_q, done_d;
  task_st_e               st_q [NUM_TASKS];
  task_st_e               st_d [NUM_TASKS];
  logic [TID_W-1:0]       rhead_q, rhead_d;
  logic [CNT_W-1:0]       rcnt_q, rcnt_d;
  logic [CNT_W-1:0]       scnt_q, scnt_d;
  logic [63:0]            ticks_q, ticks_d;
  logic [15:0]            slice_q, slice_d;
  logic [TID_W-1:0]       cur_q, cur_d;
  func_e                  func_q, func_d;
  logic [TID_W-1:0]       tid_q, tid_d;
  logic [TID_W-1:0]       nxt_q, nxt_d;
  logic [TID_W-1:0]       sid_q, sid_d;
  logic                   sw_q, sw_d;
  logic                   status_q, status_d;
  logic                   rot_q, rot_d;
  logic                   sel_stk_q, sel_stk_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       tk_q, tk_d;
  logic [31:0]            quo_q, quo_d;
  logic [9:0]             rem_q, rem_d;
  logic [4:0]             dcnt_q, dcnt_d;

  // Memories.
  logic [TID_W-1:0] q_mem [2*NUM_TASKS];
  logic [63:0]      wake_mem [NUM_TASKS];
  logic [TID_W:0]   q_raddr, q_waddr;
  logic             q_we;
  logic [TID_W-1:0] q_wdata, q_rdata_q;
  logic [TID_W-1:0] wk_raddr, wk_waddr;
  logic             wk_we;
  logic [63:0]      wk_wdata, wk_rdata_q;

  // Helpers.
  func_e            func_sel;
  logic [TID_W-1:0] tid_sel;
  task_st_e         t_st, cur_st, nxt_st;
  logic [TID_W-1:0] push_slot;
  logic [15:0]      reload;
  logic [9:0]       divisor;
  logic [CNT_W-1:0] lim, idx_inc, tk_dec;
  logic [10:0]      rem_sh;
  logic             can_push;

  assign func_sel  = (state_q == S_IDLE) ? func_e'(func_i) : func_q;
  assign tid_sel   = (state_q == S_IDLE) ? task_id_i : tid_q;
  assign t_st      = st_q[tid_sel];
  assign cur_st    = st_q[cur_q];
  assign nxt_st    = st_q[nxt_q];
  assign push_slot = rhead_q + rcnt_q[TID_W-1:0];
  assign can_push  = (rcnt_q < CNT_W'(NUM_TASKS));
  assign reload    = (slice_cfg_q == 16'd0) ? 16'd1 : slice_cfg_q;
  assign divisor   = (tickms_q == 10'd0) ? 10'd1 : tickms_q;
  assign lim       = sel_stk_q ? scnt_q : rcnt_q;
  assign idx_inc   = idx_q + CNT_W'(1);
  assign tk_dec    = tk_q - CNT_W'(1);
  assign rem_sh    = {rem_q, quo_q[31]};

  // Address of entry j of the queue or of the stack.
  function automatic logic [TID_W:0] ent_addr(input logic stk, input logic [TID_W-1:0] hd,
                                               input logic [CNT_W-1:0] j);
    ent_addr = stk ? {1'b1, j[TID_W-1:0]} : {1'b0, hd + j[TID_W-1:0]};
  endfunction

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (func_sel)
            FN_BLOCK: begin
              if (t_st == ST_READY) begin
                state_d = S_FD_RD;
              end else if (t_st == ST_RUNNING && tid_sel == cur_q) begin
                state_d = S_RS0;
              end else begin
                done_d = 1'b1;
              end
            end
            FN_SLEEP: begin
              if (cur_st == ST_RUNNING && scnt_q < CNT_W'(NUM_TASKS)) begin
                state_d = S_DIV;
              end else begin
                done_d = 1'b1;
              end
            end
            FN_YIELD: state_d = S_RS0;
            FN_TICK:  state_d = S_TK_CHK;
            FN_WAKE: begin
              if (t_st == ST_SLEEPING) begin
                state_d = S_FD_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_FD_RD:  state_d = (idx_q >= lim) ? S_CONT : S_FD_CMP;
      S_FD_CMP: state_d = (q_rdata_q == tid_q) ? S_SH_RD : S_FD_RD;
      S_SH_RD:  state_d = (idx_inc < lim) ? S_SH_WR : S_CONT;
      S_SH_WR:  state_d = S_SH_RD;
      S_CONT: begin
        priority case (func_q)
          FN_BLOCK: begin
            if (tid_q == cur_q) begin
              state_d = S_RS0;
            end else begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
          end
          FN_TICK: state_d = S_TK_CHK;
          default: begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        endcase
      end
      S_DIV:    state_d = (dcnt_q == 5'd31) ? S_SLP : S_DIV;
      S_SLP:    state_d = S_RS0;
      S_TK_CHK: state_d = (tk_q == '0) ? S_TK_SLICE : S_TK_RDW;
      S_TK_RDW: state_d = S_TK_CMP;
      S_TK_CMP: state_d = (ticks_q >= wk_rdata_q) ? S_SH_RD : S_TK_CHK;
      S_TK_SLICE: begin
        if (cur_q != idle_q && slice_q <= 16'd1) begin
          state_d = S_RS0;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_RS0: begin
        if (en_q) begin
          state_d = S_RS1;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_RS1: state_d = (rcnt_q != '0) ? S_RS2 : S_RS3;
      S_RS2: state_d = S_RS3;
      S_RS3: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    st_d      = st_q;
    rhead_d   = rhead_q;
    rcnt_d    = rcnt_q;
    scnt_d    = scnt_q;
    ticks_d   = ticks_q;
    slice_d   = slice_q;
    cur_d     = cur_q;
    func_d    = func_q;
    tid_d     = tid_q;
    nxt_d     = nxt_q;
    sid_d     = sid_q;
    sw_d      = sw_q;
    status_d  = status_q;
    rot_d     = rot_q;
    sel_stk_d = sel_stk_q;
    idx_d     = idx_q;
    tk_d      = tk_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    q_raddr   = ent_addr(sel_stk_q, rhead_q, idx_q);
    q_we      = 1'b0;
    q_waddr   = {1'b0, push_slot};
    q_wdata   = tid_q;
    wk_raddr  = q_rdata_q;
    wk_we     = 1'b0;
    wk_waddr  = cur_q;
    wk_wdata  = ticks_q + {32'd0, quo_q};
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d   = func_sel;
          tid_d    = task_id_i;
          sw_d     = 1'b0;
          status_d = 1'b0;
          idx_d    = '0;
          unique case (func_sel)
            FN_MKRDY: begin
              if (t_st == ST_INVALID) begin
                st_d[task_id_i] = ST_READY;
                q_wdata = task_id_i;
                if (can_push) begin
                  q_we   = 1'b1;
                  rcnt_d = rcnt_q + CNT_W'(1);
                end
              end else begin
                status_d = 1'b1;
              end
            end
            FN_BLOCK: begin
              sel_stk_d = 1'b0;
              rot_d     = 1'b0;
              if (t_st == ST_RUNNING) begin
                st_d[task_id_i] = ST_BLOCKED;
              end else if (t_st != ST_READY) begin
                status_d = 1'b1;
              end
            end
            FN_UNBLK: begin
              if (t_st == ST_BLOCKED) begin
                st_d[task_id_i] = ST_READY;
                q_wdata = task_id_i;
                if (can_push) begin
                  q_we   = 1'b1;
                  rcnt_d = rcnt_q + CNT_W'(1);
                end
              end else begin
                status_d = 1'b1;
              end
            end
            FN_SLEEP: begin
              quo_d  = sleep_ms_i;
              rem_d  = '0;
              dcnt_d = '0;
              rot_d  = 1'b0;
              if (!(cur_st == ST_RUNNING && scnt_q < CNT_W'(NUM_TASKS))) begin
                status_d = 1'b1;
              end
            end
            FN_YIELD: rot_d = 1'b1;
            FN_TICK: begin
              ticks_d = ticks_q + 64'd1;
              tk_d    = scnt_q;
            end
            FN_WAKE: begin
              sel_stk_d = 1'b1;
              if (t_st != ST_SLEEPING) begin
                status_d = 1'b1;
              end
            end
            default: status_d = 1'b1;
          endcase
        end
      end
      // Search for the task in the queue or the stack.
      S_FD_RD: q_raddr = ent_addr(sel_stk_q, rhead_q, idx_q);
      S_FD_CMP: begin
        if (q_rdata_q != tid_q) begin
          idx_d = idx_inc;
        end
      end
      // Close the gap left by the removed entry.
      S_SH_RD: begin
        q_raddr = ent_addr(sel_stk_q, rhead_q, idx_inc);
        if (!(idx_inc < lim)) begin
          if (sel_stk_q) begin
            scnt_d = scnt_q - CNT_W'(1);
          end else begin
            rcnt_d = rcnt_q - CNT_W'(1);
          end
        end
      end
      S_SH_WR: begin
        q_we    = 1'b1;
        q_waddr = ent_addr(sel_stk_q, rhead_q, idx_q);
        q_wdata = q_rdata_q;
        idx_d   = idx_inc;
      end
      // Finish the event that needed the removal.
      S_CONT: begin
        priority case (func_q)
          FN_BLOCK: st_d[tid_q] = ST_BLOCKED;
          FN_WAKE: begin
            st_d[tid_q] = ST_READY;
            q_wdata = tid_q;
            if (can_push) begin
              q_we   = 1'b1;
              rcnt_d = rcnt_q + CNT_W'(1);
            end
          end
          FN_TICK: begin
            st_d[sid_q] = ST_READY;
            q_wdata = sid_q;
            tk_d = tk_dec;
            if (can_push) begin
              q_we   = 1'b1;
              rcnt_d = rcnt_q + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      // One quotient bit per cycle.
      S_DIV: begin
        dcnt_d = dcnt_q + 5'd1;
        if (rem_sh >= {1'b0, divisor}) begin
          rem_d = 10'(rem_sh - {1'b0, divisor});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh[9:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
      S_SLP: begin
        wk_we   = 1'b1;
        q_we    = 1'b1;
        q_waddr = {1'b1, scnt_q[TID_W-1:0]};
        q_wdata = cur_q;
        scnt_d  = scnt_q + CNT_W'(1);
        st_d[cur_q] = ST_SLEEPING;
      end
      // Walk the sleep stack from the top.
      S_TK_CHK: q_raddr = {1'b1, tk_dec[TID_W-1:0]};
      S_TK_RDW: sid_d = q_rdata_q;
      S_TK_CMP: begin
        if (ticks_q >= wk_rdata_q) begin
          idx_d     = tk_dec;
          sel_stk_d = 1'b1;
        end else begin
          tk_d = tk_dec;
        end
      end
      S_TK_SLICE: begin
        rot_d = 1'b1;
        if (cur_q != idle_q) begin
          if (slice_q <= 16'd1) begin
            slice_d = reload;
          end else begin
            slice_d = slice_q - 16'd1;
          end
        end
      end
      // Reschedule: rotate, then take the head or the idle task.
      S_RS0: begin
        if (en_q && rot_q && cur_st == ST_RUNNING) begin
          st_d[cur_q] = ST_READY;
          q_wdata = cur_q;
          if (can_push) begin
            q_we   = 1'b1;
            rcnt_d = rcnt_q + CNT_W'(1);
          end
        end
      end
      S_RS1: begin
        q_raddr = {1'b0, rhead_q};
        nxt_d   = idle_q;
      end
      S_RS2: begin
        nxt_d   = q_rdata_q;
        rhead_d = rhead_q + TID_W'(1);
        rcnt_d  = rcnt_q - CNT_W'(1);
      end
      S_RS3: begin
        if (nxt_st == ST_READY || nxt_st == ST_INVALID) begin
          st_d[nxt_q] = ST_RUNNING;
        end
        if (nxt_q != cur_q) begin
          if (cur_st == ST_RUNNING) begin
            st_d[cur_q] = ST_READY;
            q_wdata = cur_q;
            if (can_push) begin
              q_we   = 1'b1;
              rcnt_d = rcnt_q + CNT_W'(1);
            end
          end
          cur_d   = nxt_q;
          slice_d = reload;
          sw_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      en_q        <= 1'b0;
      idle_q      <= '0;
      slice_cfg_q <= 16'd10;
      tickms_q    <= 10'd1;
      rhead_q     <= '0;
      rcnt_q      <= '0;
      scnt_q      <= '0;
      ticks_q     <= '0;
      slice_q     <= 16'd10;
      cur_q       <= '0;
      sw_q        <= 1'b0;
      status_q    <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        st_q[i] <= ST_INVALID;
      end
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      rhead_q  <= rhead_d;
      rcnt_q   <= rcnt_d;
      scnt_q   <= scnt_d;
      ticks_q  <= ticks_d;
      slice_q  <= slice_d;
      cur_q    <= cur_d;
      sw_q     <= sw_d;
      status_q <= status_d;
      st_q     <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ENABLE: en_q        <= cfg_data_i[0];
          CFG_IDLE:   idle_q      <= cfg_data_i[3:0];
          CFG_SLICE:  slice_cfg_q <= cfg_data_i;
          CFG_TICKMS: tickms_q    <= cfg_data_i[9:0];
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    tid_q     <= tid_d;
    nxt_q     <= nxt_d;
    sid_q     <= sid_d;
    rot_q     <= rot_d;
    sel_stk_q <= sel_stk_d;
    idx_q     <= idx_d;
    tk_q      <= tk_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
  end

  // Queue and stack memory.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= q_mem[q_raddr];
  end

  // Wake-time memory.
  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wake_mem[wk_waddr] <= wk_wdata;
    end
    wk_rdata_q <= wake_mem[wk_raddr];
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign running_task_o = cur_q;
  assign switched_o     = sw_q;
  assign status_o       = status_q;
  assign tick_count_o   = ticks_q;

  // Checks.
  `ASSERT_ALWAYS(a_rcnt_max, rcnt_q <= CNT_W'(NUM_TASKS))
  `ASSERT_ALWAYS(a_scnt_max, scnt_q <= CNT_W'(NUM_TASKS))
  `ASSERT_ALWAYS(a_done_idle, !(done_q && busy))
  `ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_q)

endmodule
